[hw/rtl/dsm2_serial_pulse_run_encoder_unit_assert.svh]
// ---------------------------------------------------------------------------
// DSM2 run encoder assertion macros
// Concurrent check helpers; expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DSM2_SERIAL_PULSE_RUN_ENCODER_UNIT_ASSERT_SVH
`define DSM2_SERIAL_PULSE_RUN_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DSM2SPRE_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("dsm2spre check failed");
`define DSM2SPRE_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("dsm2spre check failed");
`else
`define DSM2SPRE_ASSERT_IMP(lbl, pre, post)
`define DSM2SPRE_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[hw/rtl/dsm2spre_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsm2spre_pkg
// Shared types and constants of the DSM2 serial run encoder.
// ---------------------------------------------------------------------------
package dsm2spre_pkg;

	localparam int BIT_TICKS = 16;
	localparam int BYTE_BITS = 10;
	localparam int STOP_EXT  = 10;
	localparam int CHAN_W    = 11;
	localparam int MAX_PAIRS = 7;

	typedef logic [15:0] pair_word_t;

	// bind pattern, first byte of each pair in the low half
	localparam pair_word_t BIND_TABLE [MAX_PAIRS] = '{
		16'h0080, 16'hAA00, 16'hFF05, 16'hFF09, 16'hFF0D, 16'h5413, 16'hAA14
	};

	typedef struct packed {
		pair_word_t bytes;
		logic       final_pair;
	} pair_load_t;

endpackage

[hw/rtl/dsm2spre_run_gen.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsm2spre_run_gen
// Serializes a byte pair as 8N1 and emits one line-level run per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module dsm2spre_run_gen (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load_valid,
	output logic                     load_ready,
	input  dsm2spre_pkg::pair_load_t load,
	input  logic [15:0]              gap,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [15:0]              pulse_width,
	output logic                     line_level,
	output logic                     frame_done,
	output logic                     last
);

	logic                                busy_q;
	logic [dsm2spre_pkg::BYTE_BITS-1:0] seq_q;
	logic [7:0]                          nxt_q;
	logic                                second_q;
	logic [3:0]                          rem_q;
	logic                                final_q;

	logic        ovalid_q;
	logic [15:0] pulse_q;
	logic        level_q;
	logic        done_q;
	logic        olast_q;

	logic        ofree;
	logic        advance;
	logic        level;
	logic [3:0]  k;
	logic        byte_end;
	logic        tick_end;
	logic [4:0]  units;
	logic [15:0] width;
	logic        load_fire;

	assign ofree     = !ovalid_q || out_ready;
	assign advance   = busy_q && ofree;
	assign level     = seq_q[0];
	assign byte_end  = (k == rem_q);
	assign tick_end  = byte_end && second_q;
	assign load_ready = !busy_q || (advance && tick_end);
	assign load_fire = load_valid && load_ready;

	// run length: first level change inside the byte, else the rest of it
	always_comb begin
		k = rem_q;
		for (int j = dsm2spre_pkg::BYTE_BITS - 1; j >= 1; j--) begin
			if ((4'(j) < rem_q) && (seq_q[j] != level)) begin
				k = 4'(j);
			end
		end
	end

	always_comb begin
		units = {1'b0, k} + (byte_end ? 5'(dsm2spre_pkg::STOP_EXT) : 5'd0);
		width = 16'(units * dsm2spre_pkg::BIT_TICKS) - 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load_fire) begin
			busy_q <= 1'b1;
		end else if (advance && tick_end) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			seq_q    <= {1'b1, load.bytes[7:0], 1'b0};
			nxt_q    <= load.bytes[15:8];
			second_q <= 1'b0;
			rem_q    <= 4'(dsm2spre_pkg::BYTE_BITS);
			final_q  <= load.final_pair;
		end else if (advance) begin
			if (byte_end) begin
				seq_q    <= {1'b1, nxt_q, 1'b0};
				second_q <= 1'b1;
				rem_q    <= 4'(dsm2spre_pkg::BYTE_BITS);
			end else begin
				seq_q <= seq_q >> k;
				rem_q <= rem_q - k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q <= (tick_end && final_q) ? gap : width;
			level_q <= level;
			done_q  <= tick_end && final_q;
			olast_q <= tick_end;
		end
	end

	assign out_valid   = ovalid_q;
	assign pulse_width = pulse_q;
	assign line_level  = level_q;
	assign frame_done  = done_q;
	assign last        = olast_q;

endmodule

[hw/rtl/dsm2_serial_pulse_run_encoder_unit.sv]
`timescale 1ns / 1ps
// The first run of a tick passes the input register, the serializer and the output register.
// Throughput: one run per cycle when the output is not stalled; a tick takes 4 to 20 runs
// in the serializer, and the next tick waits in the input register meanwhile.
// Reset: bind pattern loaded, bind latch set, pair slot 0, frame gap 39999.
// ---------------------------------------------------------------------------
// dsm2_serial_pulse_run_encoder_unit
// DSM2 frame builder and 8N1 run-width encoder, two bytes per slot tick.
// ---------------------------------------------------------------------------
`include "dsm2_serial_pulse_run_encoder_unit_assert.svh"

module dsm2_serial_pulse_run_encoder_unit #(
	parameter int CHANNELS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // chan_0 .. chan_5, 11 bits each, zero pad
	input  logic        s_axis_tuser,  // bind_switch
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // pulse_width[15:0], line_level, zero pad
	output logic        m_axis_tuser,  // frame_done
	output logic        m_axis_tlast,  // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data       // frame_gap_ticks
);

	localparam int PAIRS  = CHANNELS + 1;
	localparam int SLOT_W = $clog2(PAIRS);

	logic                valid_s1;
	logic [71:0]         data_s1;
	logic                sw_s1;

	logic                bind_active_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [15:0]         gap_q;
	dsm2spre_pkg::pair_word_t frame_q [PAIRS];
	dsm2spre_pkg::pair_word_t build [PAIRS];

	logic                     rebuild;
	logic                     is_final;
	logic                     load_ready;
	logic                     load_fire;
	dsm2spre_pkg::pair_load_t load;

	logic [15:0] pulse_width;
	logic        line_level;

	assign s_axis_tready = !valid_s1 || load_ready;
	assign load_fire     = valid_s1 && load_ready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			sw_s1   <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 16'd39999;
		end else if (cfg_valid && cfg_ready) begin
			gap_q <= cfg_data;
		end
	end

	assign rebuild  = (slot_q == '0) && !(bind_active_q && sw_s1);
	assign is_final = (slot_q == SLOT_W'(CHANNELS));

	// new frame from the channels: header 00 00, then index/high bits and low byte
	always_comb begin
		logic signed [11:0] p;
		logic [9:0]         pc;
		build[0] = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			p = $signed({data_s1[i*dsm2spre_pkg::CHAN_W + dsm2spre_pkg::CHAN_W - 1],
				data_s1[i*dsm2spre_pkg::CHAN_W +: dsm2spre_pkg::CHAN_W]}) + 12'sd512;
			if (p[11]) begin
				pc = 10'd0;
			end else if (p[10]) begin
				pc = 10'd1023;
			end else begin
				pc = p[9:0];
			end
			build[i+1] = {pc[7:0], 3'b000, 3'(i), pc[9:8]};
		end
	end

	always_comb begin
		load.bytes      = rebuild ? build[0] : frame_q[slot_q];
		load.final_pair = is_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bind_active_q <= 1'b1;
			slot_q        <= '0;
			for (int i = 0; i < PAIRS; i++) begin
				frame_q[i] <= dsm2spre_pkg::BIND_TABLE[i];
			end
		end else if (load_fire) begin
			slot_q <= is_final ? '0 : slot_q + 1'b1;
			if (rebuild) begin
				bind_active_q <= 1'b0;
				for (int i = 0; i < PAIRS; i++) begin
					frame_q[i] <= build[i];
				end
			end
		end
	end

	dsm2spre_run_gen u_run_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_ready  (load_ready),
		.load        (load),
		.gap         (gap_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.pulse_width (pulse_width),
		.line_level  (line_level),
		.frame_done  (m_axis_tuser),
		.last        (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, line_level, pulse_width};

	`DSM2SPRE_ASSERT_IMP(a_done_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`DSM2SPRE_ASSERT_IMP(a_slot_range, 1'b1, slot_q <= SLOT_W'(CHANNELS))
	`DSM2SPRE_ASSERT_NEXT(a_bind_sticky, !bind_active_q, !bind_active_q)
	`DSM2SPRE_ASSERT_NEXT(a_final_wraps, load_fire && is_final, slot_q == '0)

endmodule
